// File: rtl/core/string_insertion_sorter_assert.svh
// Assertion helpers for the string sorter; clk and rst_n are the sampling pair.
`ifndef STRING_INSERTION_SORTER_ASSERT_SVH
`define STRING_INSERTION_SORTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sis_pkg.sv
package sis_pkg;

  localparam int ChunkBits = 64;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [ChunkBits-1:0] chunk_data;
    logic [1:0]           chunk_index;
    logic [5:0]           word_index;
  } in_item_t;

  typedef struct packed {
    logic [ChunkBits-1:0] read_data;
    logic [6:0]           word_count;
    logic [1:0]           status;
  } out_item_t;

endpackage

// File: rtl/core/string_insertion_sorter.sv
// Flow: a chunk load, clear or rejected op passes S_OUT into the output register;
//   a read passes S_RDATA first; an insertion runs S_RD and S_CMP per word moved up,
//   plus once to stop unless it lands in row zero, then S_PUT and S_OUT.
// One item at a time: in_ready is high only in S_IDLE; an output stall holds S_OUT.
// Reset (rst_n low, synchronous): controller idle, count zero, output empty.
//   Table rows and staging chunks are not cleared; reads never reach unwritten rows.
module string_insertion_sorter #(
  parameter int MAX_WORDS   = 64,
  parameter int WORD_CHUNKS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sis_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sis_pkg::out_item_t  out_data
);

`include "string_insertion_sorter_assert.svh"

  // Geometry: one table row holds a whole word, chunk 0 (first bytes) in the low slice.
  localparam int RowBits = WORD_CHUNKS * sis_pkg::ChunkBits;
  localparam int AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW      = $clog2(MAX_WORDS + 1);
  localparam int StgDep  = (WORD_CHUNKS > 1) ? WORD_CHUNKS - 1 : 1;

  // Controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;  // read the row just below the insertion point
  localparam logic [2:0] S_CMP   = 3'd2;  // compare it; move it up or stop
  localparam logic [2:0] S_PUT   = 3'd3;  // write the new word into the hole
  localparam logic [2:0] S_RDATA = 3'd4;  // read op: row data back from the table
  localparam logic [2:0] S_OUT   = 3'd5;  // hand the result to the output register

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [1:0]             csel_r, csel_nxt;
  logic [RowBits-1:0]     word_r, word_nxt;
  sis_pkg::out_item_t     res_r, res_nxt;
  sis_pkg::out_item_t     out_data_r;
  logic                   out_valid_r;

  // Staging for the leading chunks of the word being loaded
  logic [sis_pkg::ChunkBits-1:0] stage_r [StgDep];

  // Sorted table: one synchronous memory, one write and one read port
  logic [RowBits-1:0]     mem [MAX_WORDS];
  logic [RowBits-1:0]     mem_q;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic [RowBits-1:0]     wr_data;

  logic                   in_xfer;
  logic                   last_chunk;
  logic                   mid_chunk;
  logic [RowBits-1:0]     new_word;

  // Comparator: stored row (mem_q) greater than the new word (word_r), strcmp order
  logic [WORD_CHUNKS-1:0] ch_dec;
  logic [WORD_CHUNKS-1:0] ch_gt;
  logic                   row_greater;
  logic                   dec_any;
  logic [sis_pkg::ChunkBits-1:0] rd_chunk;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign last_chunk = (32'(in_data.chunk_index) == 32'(WORD_CHUNKS - 1));
  assign mid_chunk  = (32'(in_data.chunk_index) <  32'(WORD_CHUNKS - 1));

  // Word as it will be stored: staged chunks plus the one arriving now
  always_comb begin
    new_word = '0;
    for (int c = 0; c < WORD_CHUNKS - 1; c++) begin
      new_word[c*sis_pkg::ChunkBits +: sis_pkg::ChunkBits] = stage_r[c];
    end
    new_word[(WORD_CHUNKS-1)*sis_pkg::ChunkBits +: sis_pkg::ChunkBits] = in_data.chunk_data;
  end

  // Per chunk: first byte that differs, or a shared terminator, decides
  always_comb begin
    for (int c = 0; c < WORD_CHUNKS; c++) begin
      ch_dec[c] = 1'b0;
      ch_gt[c]  = 1'b0;
      for (int j = 0; j < 8; j++) begin
        if (!ch_dec[c]) begin
          if (mem_q[c*64 + 63 - 8*j -: 8] != word_r[c*64 + 63 - 8*j -: 8]) begin
            ch_dec[c] = 1'b1;
            ch_gt[c]  = (mem_q[c*64 + 63 - 8*j -: 8] > word_r[c*64 + 63 - 8*j -: 8]);
          end else if (mem_q[c*64 + 63 - 8*j -: 8] == 8'd0) begin
            ch_dec[c] = 1'b1;
          end
        end
      end
    end
  end

  // Across chunks: earliest deciding chunk wins; none deciding means equal
  always_comb begin
    dec_any     = 1'b0;
    row_greater = 1'b0;
    for (int c = 0; c < WORD_CHUNKS; c++) begin
      if (!dec_any && ch_dec[c]) begin
        dec_any     = 1'b1;
        row_greater = ch_gt[c];
      end
    end
  end

  // Chunk pick for read ops; chunk numbers past the word give zero
  always_comb begin
    rd_chunk = '0;
    for (int c = 0; c < WORD_CHUNKS; c++) begin
      if ({30'd0, csel_r} == 32'(c)) begin
        rd_chunk = mem_q[c*sis_pkg::ChunkBits +: sis_pkg::ChunkBits];
      end
    end
  end

  // Read address: the requested row while idle, else the row below pos
  assign rd_addr = (state_r == S_IDLE) ? AW'(in_data.word_index) : AW'(pos_r - 1'b1);

  // Controller
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    csel_nxt  = csel_r;
    word_nxt  = word_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    wr_addr   = pos_r;
    wr_data   = word_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt.read_data  = '0;
          res_nxt.word_count = 7'(count_r);
          res_nxt.status     = sis_pkg::ST_OK;
          state_nxt          = S_OUT;
          unique case (in_data.opcode)
            sis_pkg::OP_LOAD: begin
              if (last_chunk) begin
                if (32'(count_r) >= 32'(MAX_WORDS)) begin
                  res_nxt.status = sis_pkg::ST_FULL;
                end else begin
                  word_nxt  = new_word;
                  pos_nxt   = AW'(count_r);
                  state_nxt = (count_r == '0) ? S_PUT : S_RD;
                end
              end
            end
            sis_pkg::OP_READ: begin
              if (32'(in_data.word_index) >= 32'(count_r)) begin
                res_nxt.status = sis_pkg::ST_RANGE;
              end else begin
                csel_nxt  = in_data.chunk_index;
                state_nxt = S_RDATA;
              end
            end
            sis_pkg::OP_CLEAR: begin
              count_nxt          = '0;
              res_nxt.word_count = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (row_greater) begin
          // move the stored word up one place and keep walking down
          mem_we    = 1'b1;
          wr_data   = mem_q;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = (pos_r == AW'(1)) ? S_PUT : S_RD;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        mem_we             = 1'b1;
        count_nxt          = count_r + 1'b1;
        res_nxt.read_data  = '0;
        res_nxt.word_count = 7'(count_r + 1'b1);
        res_nxt.status     = sis_pkg::ST_OK;
        state_nxt          = S_OUT;
      end
      S_RDATA: begin
        res_nxt.read_data = rd_chunk;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    csel_r <= csel_nxt;
    word_r <= word_nxt;
    res_r  <= res_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  // Staging writes on loads of any chunk but the last
  always_ff @(posedge clk) begin
    if (in_xfer && in_data.opcode == sis_pkg::OP_LOAD && mid_chunk) begin
      for (int s = 0; s < StgDep; s++) begin
        if ({30'd0, in_data.chunk_index} == 32'(s)) begin
          stage_r[s] <= in_data.chunk_data;
        end
      end
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  `SIS_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_r) <= 32'(MAX_WORDS),
    "stored count beyond table size")
  `SIS_ASSERT_SAME(a_write_phase, mem_we, state_r == S_CMP || state_r == S_PUT,
    "table written outside the insertion walk")
  `SIS_ASSERT_SAME(a_walk_pos, state_r == S_RD || state_r == S_CMP, pos_r != '0,
    "insertion walk below row zero")
  `SIS_ASSERT_NEXT(a_put_count, state_r == S_PUT,
    32'(count_r) == 32'($past(count_r)) + 32'd1, "insert did not bump the count")

endmodule
